// File: rtl/tlgs_pkg.sv
`default_nettype none

package tlgs_pkg;

    localparam int GRID_ROWS = 64;
    localparam int GRID_COLS = 64;
    localparam int ROW_W     = $clog2(GRID_ROWS);
    localparam int COL_W     = $clog2(GRID_COLS);
    localparam int SIZE_W    = 7;

    localparam logic [SIZE_W-1:0] MAX_WIDTH  = SIZE_W'(GRID_COLS);
    localparam logic [SIZE_W-1:0] MAX_HEIGHT = SIZE_W'(GRID_ROWS);

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_STEP  = 2'd2;

    localparam logic [3:0] SURVIVE_LO = 4'd2;
    localparam logic [3:0] BIRTH_CNT  = 4'd3;

    typedef enum logic [1:0] {
        RD_ITEM,
        RD_LAST,
        RD_ZERO,
        RD_PTR
    } rd_sel_t;

    typedef struct packed {
        logic    latch;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    load_prev;
        logic    load_cur;
        logic    row_step;
        logic    wr_cell;
        logic    cap_read;
        logic    load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       in_grid;
        logic       last_row;
        logic       out_free;
    } dp_stat_t;

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input logic [SIZE_W-1:0] maxv);
        logic [SIZE_W-1:0] r;
        if (v == '0)
            r = SIZE_W'(1);
        else if (v > maxv)
            r = maxv;
        else
            r = v;
        return r;
    endfunction

    function automatic logic [GRID_COLS-1:0] life_row(input logic [GRID_COLS-1:0] up,
                                                      input logic [GRID_COLS-1:0] mid,
                                                      input logic [GRID_COLS-1:0] dn,
                                                      input logic [SIZE_W-1:0]    w);
        logic [COL_W-1:0]     last;
        logic [COL_W-1:0]     lc;
        logic [COL_W-1:0]     rc;
        logic [3:0]           cnt;
        logic [GRID_COLS-1:0] res;
        last = COL_W'(w - SIZE_W'(1));
        res  = mid;
        for (int c = 0; c < GRID_COLS; c++)
        begin
            lc  = (c == 0) ? last : COL_W'(c - 1);
            rc  = (COL_W'(c) == last) ? '0 : COL_W'(c + 1);
            cnt = 4'(up[lc]) + 4'(up[c]) + 4'(up[rc])
                + 4'(mid[lc]) + 4'(mid[rc])
                + 4'(dn[lc]) + 4'(dn[c]) + 4'(dn[rc]);
            if (SIZE_W'(c) < w)
            begin
                if (mid[c])
                    res[c] = (cnt == SURVIVE_LO) || (cnt == BIRTH_CNT);
                else
                    res[c] = (cnt == BIRTH_CNT);
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// File: rtl/toroidal_life_grid_step_top.sv
// Life grid on a torus (birth on 3, survival on 2 or 3), 64 x 64 cells.
// Slave channel s_*: one request per item: write a cell, read a cell, or
// advance the grid one generation. Master channel m_*: one result per request.
// APB port: register 0 (address 0) is the width in use, register 1
// (address 4) the height in use; 0 acts as 1, above 64 acts as 64.
// Write only while the block is idle.
// A read or write of a cell inside the grid goes through decode, a row read,
// then a write-back or bit capture, then the output stage; an address outside
// it or command 3 goes straight from decode to the output stage. An advance
// streams one 64-cell row per cycle through the row memory, after three priming reads.
// One request is in work at a time; s_tready is high only when idle.
// A finished result sits in an output register; a new request is taken while
// it waits, and the next result holds until m_tready frees the register.
// Reset clears every cell (per-row valid flags), sets both sizes to 64 and
// empties the output register.
`default_nettype none

module toroidal_life_grid_step_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,  // cmd[1:0], row_index[7:2], col_index[13:8], write_alive[14]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,  // read_alive[0], step_done[1]
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [tlgs_pkg::SIZE_W-1:0] width_reg;
    logic [tlgs_pkg::SIZE_W-1:0] height_reg;
    logic                        cfg_wr;
    tlgs_pkg::dp_cmd_t           dp_cmd;
    tlgs_pkg::dp_stat_t          dp_stat;
    logic                        read_alive;
    logic                        step_done;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= tlgs_pkg::MAX_WIDTH;
            height_reg <= tlgs_pkg::MAX_HEIGHT;
        end
        else if (cfg_wr)
        begin
            if (paddr[2])
                height_reg <= pwdata[tlgs_pkg::SIZE_W-1:0];
            else
                width_reg <= pwdata[tlgs_pkg::SIZE_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2])
            prdata[tlgs_pkg::SIZE_W-1:0] = height_reg;
        else
            prdata[tlgs_pkg::SIZE_W-1:0] = width_reg;
    end

    tlgs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (dp_stat),
        .cmd      (dp_cmd)
    );

    tlgs_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (dp_cmd),
        .stat       (dp_stat),
        .in_cmd     (s_tdata[1:0]),
        .in_row     (s_tdata[7:2]),
        .in_col     (s_tdata[13:8]),
        .in_alive   (s_tdata[14]),
        .cfg_width  (width_reg),
        .cfg_height (height_reg),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .read_alive (read_alive),
        .step_done  (step_done)
    );

    assign m_tdata = {6'b0, step_done, read_alive};

endmodule

`default_nettype wire

// File: rtl/tlgs_ctrl.sv
`default_nettype none

module tlgs_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire tlgs_pkg::dp_stat_t stat,
    output tlgs_pkg::dp_cmd_t      cmd
);

    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_DECODE   = 9'b000000010,
        ST_CELL_RD  = 9'b000000100,
        ST_CELL_WR  = 9'b000001000,
        ST_CELL_OUT = 9'b000010000,
        ST_ADV_S0   = 9'b000100000,
        ST_ADV_S1   = 9'b001000000,
        ST_ADV_S2   = 9'b010000000,
        ST_DONE     = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   adv_row_reg;
    logic   adv_row_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            adv_row_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            adv_row_reg <= adv_row_next;
        end
    end

    always_comb
    begin
        cmd          = '0;
        cmd.rd_sel   = tlgs_pkg::RD_ITEM;
        state_next   = state_reg;
        adv_row_next = adv_row_reg;
        s_tready     = 1'b0;
        if (adv_row_reg)
        begin
            // one new row per cycle, read two rows ahead
            cmd.rd_en    = 1'b1;
            cmd.rd_sel   = tlgs_pkg::RD_PTR;
            cmd.row_step = 1'b1;
            if (stat.last_row)
            begin
                adv_row_next = 1'b0;
                state_next   = ST_DONE;
            end
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    s_tready = 1'b1;
                    if (s_tvalid)
                    begin
                        cmd.latch  = 1'b1;
                        state_next = ST_DECODE;
                    end
                end
                ST_DECODE:
                begin
                    unique case (stat.cmd) inside
                        tlgs_pkg::CMD_WRITE, tlgs_pkg::CMD_READ:
                            state_next = stat.in_grid ? ST_CELL_RD : ST_DONE;
                        tlgs_pkg::CMD_STEP:
                            state_next = ST_ADV_S0;
                        default:
                            state_next = ST_DONE;
                    endcase
                end
                ST_CELL_RD:
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = tlgs_pkg::RD_ITEM;
                    state_next = (stat.cmd == tlgs_pkg::CMD_WRITE) ? ST_CELL_WR : ST_CELL_OUT;
                end
                ST_CELL_WR:
                begin
                    cmd.wr_cell = 1'b1;
                    state_next  = ST_DONE;
                end
                ST_CELL_OUT:
                begin
                    cmd.cap_read = 1'b1;
                    state_next   = ST_DONE;
                end
                ST_ADV_S0:
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = tlgs_pkg::RD_LAST;
                    state_next = ST_ADV_S1;
                end
                ST_ADV_S1:
                begin
                    cmd.rd_en     = 1'b1;
                    cmd.rd_sel    = tlgs_pkg::RD_ZERO;
                    cmd.load_prev = 1'b1;
                    state_next    = ST_ADV_S2;
                end
                ST_ADV_S2:
                begin
                    cmd.rd_en    = 1'b1;
                    cmd.rd_sel   = tlgs_pkg::RD_PTR;
                    cmd.load_cur = 1'b1;
                    adv_row_next = 1'b1;
                    state_next   = ST_DONE;
                end
                ST_DONE:
                begin
                    if (stat.out_free)
                    begin
                        cmd.load_out = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end
                default:
                    state_next = ST_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: rtl/tlgs_dp.sv
`default_nettype none

module tlgs_dp (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire tlgs_pkg::dp_cmd_t                 cmd,
    output tlgs_pkg::dp_stat_t                     stat,
    input  wire logic [1:0]                        in_cmd,
    input  wire logic [tlgs_pkg::ROW_W-1:0]        in_row,
    input  wire logic [tlgs_pkg::COL_W-1:0]        in_col,
    input  wire logic                              in_alive,
    input  wire logic [tlgs_pkg::SIZE_W-1:0]       cfg_width,
    input  wire logic [tlgs_pkg::SIZE_W-1:0]       cfg_height,
    input  wire logic                              out_ready,
    output logic                                   out_valid,
    output logic                                   read_alive,
    output logic                                   step_done
);

    logic [tlgs_pkg::GRID_COLS-1:0] mem [tlgs_pkg::GRID_ROWS];

    logic [1:0]                     cmd_reg;
    logic [tlgs_pkg::ROW_W-1:0]     row_reg;
    logic [tlgs_pkg::COL_W-1:0]     col_reg;
    logic                           alive_reg;
    logic [tlgs_pkg::SIZE_W-1:0]    w_reg;
    logic [tlgs_pkg::SIZE_W-1:0]    h_reg;
    logic [tlgs_pkg::GRID_COLS-1:0] mem_q_reg;
    logic                           mem_v_reg;
    logic [tlgs_pkg::GRID_ROWS-1:0] row_valid_reg;
    logic [tlgs_pkg::ROW_W-1:0]     rd_ptr_reg;
    logic [tlgs_pkg::ROW_W-1:0]     row_cnt_reg;
    logic [tlgs_pkg::GRID_COLS-1:0] prev_reg;
    logic [tlgs_pkg::GRID_COLS-1:0] cur_reg;
    logic [tlgs_pkg::GRID_COLS-1:0] first_reg;
    logic                           read_bit_reg;
    logic                           out_valid_reg;
    logic                           read_alive_reg;
    logic                           step_done_reg;

    logic [tlgs_pkg::ROW_W-1:0]     h_last;
    logic [tlgs_pkg::ROW_W-1:0]     rd_addr;
    logic [tlgs_pkg::ROW_W-1:0]     rd_ptr_next;
    logic [tlgs_pkg::GRID_COLS-1:0] rdata;
    logic [tlgs_pkg::GRID_COLS-1:0] nxt_row;
    logic [tlgs_pkg::GRID_COLS-1:0] new_row;
    logic [tlgs_pkg::GRID_COLS-1:0] cell_row;
    logic                           wr_en;
    logic [tlgs_pkg::ROW_W-1:0]     wr_addr;
    logic [tlgs_pkg::GRID_COLS-1:0] wr_data;
    logic                           last_row;
    logic                           out_free;

    assign h_last = tlgs_pkg::ROW_W'(h_reg - tlgs_pkg::SIZE_W'(1));

    always_comb
    begin
        unique case (cmd.rd_sel)
            tlgs_pkg::RD_ITEM: rd_addr = row_reg;
            tlgs_pkg::RD_LAST: rd_addr = h_last;
            tlgs_pkg::RD_ZERO: rd_addr = '0;
            tlgs_pkg::RD_PTR:  rd_addr = rd_ptr_reg;
            default:           rd_addr = '0;
        endcase
    end

    assign rd_ptr_next = (rd_addr == h_last) ? '0 : rd_addr + tlgs_pkg::ROW_W'(1);
    assign rdata       = mem_v_reg ? mem_q_reg : '0;
    assign last_row    = (row_cnt_reg == h_last);
    assign nxt_row     = last_row ? first_reg : rdata;
    assign new_row     = tlgs_pkg::life_row(prev_reg, cur_reg, nxt_row, w_reg);

    always_comb
    begin
        cell_row          = rdata;
        cell_row[col_reg] = alive_reg;
    end

    assign wr_en   = cmd.row_step | cmd.wr_cell;
    assign wr_addr = cmd.row_step ? row_cnt_reg : row_reg;
    assign wr_data = cmd.row_step ? new_row : cell_row;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (cmd.rd_en)
            mem_q_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            mem_v_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.rd_en)
                mem_v_reg <= row_valid_reg[rd_addr];
            if (wr_en)
                row_valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            cmd_reg   <= in_cmd;
            row_reg   <= in_row;
            col_reg   <= in_col;
            alive_reg <= in_alive;
            w_reg     <= tlgs_pkg::clamp_size(cfg_width, tlgs_pkg::MAX_WIDTH);
            h_reg     <= tlgs_pkg::clamp_size(cfg_height, tlgs_pkg::MAX_HEIGHT);
        end
        if (cmd.rd_en)
            rd_ptr_reg <= rd_ptr_next;
        if (cmd.latch)
            row_cnt_reg <= '0;
        else if (cmd.row_step)
            row_cnt_reg <= row_cnt_reg + tlgs_pkg::ROW_W'(1);
        if (cmd.load_prev)
            prev_reg <= rdata;
        if (cmd.load_cur)
        begin
            cur_reg   <= rdata;
            first_reg <= rdata;
        end
        if (cmd.row_step)
        begin
            prev_reg <= cur_reg;
            cur_reg  <= nxt_row;
        end
        if (cmd.cap_read)
            read_bit_reg <= rdata[col_reg];
        if (cmd.load_out)
        begin
            read_alive_reg <= (cmd_reg == tlgs_pkg::CMD_READ) && stat.in_grid && read_bit_reg;
            step_done_reg  <= (cmd_reg == tlgs_pkg::CMD_STEP);
        end
    end

    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_out)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_comb
    begin
        stat.cmd      = cmd_reg;
        stat.in_grid  = ({1'b0, row_reg} < h_reg) && ({1'b0, col_reg} < w_reg);
        stat.last_row = last_row;
        stat.out_free = out_free;
    end

    assign out_valid  = out_valid_reg;
    assign read_alive = read_alive_reg;
    assign step_done  = step_done_reg;

endmodule

`default_nettype wire

// File: tb/tb_toroidal_life_grid_step_top.sv
`default_nettype none

module tb_toroidal_life_grid_step_top;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int REG_WIDTH  = 0;
    localparam int REG_HEIGHT = 1;
    localparam int PHASES     = 13;
    localparam int PHASE_ITEMS = 150;

    typedef struct packed {
        logic read_alive;
        logic step_done;
    } life_outcome_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    wire logic   s_tready;
    logic [15:0] s_tdata = '0;
    wire logic   m_tvalid;
    logic        m_tready = 1'b0;
    wire logic [7:0] m_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    wire logic [31:0] prdata;
    wire logic   pready;

    logic [tlgs_pkg::GRID_COLS-1:0] shadow_cells [tlgs_pkg::GRID_ROWS];
    logic [tlgs_pkg::SIZE_W-1:0]    width_reg;
    logic [tlgs_pkg::SIZE_W-1:0]    height_reg;

    logic [15:0]   request_q [$];
    life_outcome_t outcome_q [$];

    int burst_left = 1;
    int gap_left = 0;
    int hold_left = 0;
    int stall_mode = 0;
    int cycle_count = 0;
    int results_seen = 0;
    int fail_count = 0;

    int phase_width  [PHASES] = '{8, 1, 2, 1, 64, 0, 127, 3, 64, 17, 5, 100, 64};
    int phase_height [PHASES] = '{8, 1, 2, 64, 1, 0, 100, 5, 64, 2, 64, 3, 64};

    toroidal_life_grid_step_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #10 clk = ~clk;

    function automatic int eff_size(input logic [tlgs_pkg::SIZE_W-1:0] v, input int maxv);
        int r;
        r = int'(v);
        if (r < 1)
            r = 1;
        else if (r > maxv)
            r = maxv;
        return r;
    endfunction

    task automatic apply_command(input logic [15:0] req);
        logic [1:0]                     cmd;
        int                             row;
        int                             col;
        int                             w;
        int                             h;
        int                             alive_near;
        int                             nr;
        int                             nc;
        logic [tlgs_pkg::GRID_COLS-1:0] next_rows [tlgs_pkg::GRID_ROWS];
        life_outcome_t                  got;
        cmd = req[1:0];
        row = int'(req[7:2]);
        col = int'(req[13:8]);
        w   = eff_size(width_reg, tlgs_pkg::GRID_COLS);
        h   = eff_size(height_reg, tlgs_pkg::GRID_ROWS);
        got = '0;
        case (cmd)
            tlgs_pkg::CMD_WRITE:
            begin
                if (row < h && col < w)
                    shadow_cells[row][col] = req[14];
            end
            tlgs_pkg::CMD_READ:
            begin
                if (row < h && col < w)
                    got.read_alive = shadow_cells[row][col];
            end
            tlgs_pkg::CMD_STEP:
            begin
                next_rows = shadow_cells;
                for (int r = 0; r < h; r++)
                begin
                    for (int c = 0; c < w; c++)
                    begin
                        alive_near = 0;
                        for (int dr = -1; dr <= 1; dr++)
                        begin
                            for (int dc = -1; dc <= 1; dc++)
                            begin
                                if (dr != 0 || dc != 0)
                                begin
                                    nr = (r + h + dr) % h;
                                    nc = (c + w + dc) % w;
                                    alive_near += int'(shadow_cells[nr][nc]);
                                end
                            end
                        end
                        if (shadow_cells[r][c])
                            next_rows[r][c] = (alive_near == 2) || (alive_near == 3);
                        else
                            next_rows[r][c] = (alive_near == 3);
                    end
                end
                shadow_cells = next_rows;
                got.step_done = 1'b1;
            end
            default: ;
        endcase
        outcome_q.push_back(got);
    endtask

    task automatic push_request(input logic [1:0] cmd, input int row, input int col,
                                input logic alive);
        request_q.push_back({1'b0, alive, 6'(col), 6'(row), cmd});
    endtask

    task automatic fill_random(input int count);
        int   w;
        int   h;
        int   pick;
        int   row;
        int   col;
        logic alive;
        w = eff_size(width_reg, tlgs_pkg::GRID_COLS);
        h = eff_size(height_reg, tlgs_pkg::GRID_ROWS);
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 99) < 85)
            begin
                row = $urandom_range(0, h - 1);
                col = $urandom_range(0, w - 1);
            end
            else
            begin
                row = $urandom_range(0, 63);
                col = $urandom_range(0, 63);
            end
            alive = ($urandom_range(0, 9) < 6);
            if (pick < 40)
                push_request(tlgs_pkg::CMD_WRITE, row, col, alive);
            else if (pick < 80)
                push_request(tlgs_pkg::CMD_READ, row, col, alive);
            else if (pick < 94)
                push_request(tlgs_pkg::CMD_STEP, row, col, alive);
            else
                push_request(CMD_UNUSED, row, col, alive);
        end
    endtask

    task automatic wait_idle();
        while (request_q.size() != 0 || s_tvalid || outcome_q.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic apb_write(input int index, input int value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(4 * index);
        pwdata  <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (index == REG_WIDTH)
            width_reg = tlgs_pkg::SIZE_W'(value);
        else
            height_reg = tlgs_pkg::SIZE_W'(value);
    endtask

    task automatic note_mismatch(input string what, input int want, input int got);
        fail_count++;
        if (fail_count <= 10)
            $display("mismatch %s: expected %0d, actual %0d (result %0d)",
                     what, want, got, results_seen);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                apply_command(s_tdata);
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (request_q.size() > 0)
                begin
                    s_tdata  <= request_q.pop_front();
                    s_tvalid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        life_outcome_t want;
        logic          ready_next;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (outcome_q.size() == 0)
                    note_mismatch("unexpected result", 0, int'(m_tdata));
                else
                begin
                    want = outcome_q.pop_front();
                    if (m_tdata[0] !== want.read_alive)
                        note_mismatch("read_alive", int'(want.read_alive), int'(m_tdata[0]));
                    if (m_tdata[1] !== want.step_done)
                        note_mismatch("step_done", int'(want.step_done), int'(m_tdata[1]));
                end
                // hold off long enough for the block to back up its input
                if (results_seen % 300 == 150)
                    hold_left = $urandom_range(150, 300);
            end
            cycle_count++;
            if (cycle_count % 128 == 0)
                stall_mode = $urandom_range(0, 3);
            if (hold_left > 0)
            begin
                hold_left--;
                ready_next = 1'b0;
            end
            else
            begin
                case (stall_mode)
                    0:       ready_next = 1'b1;
                    1:       ready_next = 1'($urandom_range(0, 1));
                    2:       ready_next = ($urandom_range(0, 3) == 0);
                    default: ready_next = cycle_count[0];
                endcase
            end
            m_tready <= ready_next;
        end
    end

    initial
    begin
        #20000000;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        for (int r = 0; r < tlgs_pkg::GRID_ROWS; r++)
            shadow_cells[r] = '0;
        width_reg  = tlgs_pkg::SIZE_W'(64);
        height_reg = tlgs_pkg::SIZE_W'(64);
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        push_request(tlgs_pkg::CMD_WRITE, 0, 0, 1'b1);
        push_request(tlgs_pkg::CMD_WRITE, 63, 63, 1'b1);
        push_request(tlgs_pkg::CMD_READ, 0, 0, 1'b0);
        push_request(tlgs_pkg::CMD_READ, 63, 63, 1'b0);
        push_request(tlgs_pkg::CMD_READ, 0, 1, 1'b1);
        push_request(tlgs_pkg::CMD_WRITE, 10, 10, 1'b1);
        push_request(tlgs_pkg::CMD_WRITE, 10, 11, 1'b1);
        push_request(tlgs_pkg::CMD_WRITE, 10, 12, 1'b1);
        push_request(CMD_UNUSED, 5, 5, 1'b1);
        push_request(tlgs_pkg::CMD_READ, 5, 5, 1'b0);
        push_request(tlgs_pkg::CMD_STEP, 0, 0, 1'b0);
        push_request(tlgs_pkg::CMD_READ, 9, 11, 1'b0);
        push_request(tlgs_pkg::CMD_READ, 11, 11, 1'b0);
        push_request(tlgs_pkg::CMD_READ, 10, 10, 1'b0);
        push_request(tlgs_pkg::CMD_READ, 0, 0, 1'b0);
        push_request(tlgs_pkg::CMD_STEP, 63, 63, 1'b1);
        push_request(tlgs_pkg::CMD_READ, 10, 10, 1'b0);
        // vertical blinker straddling the row wrap
        push_request(tlgs_pkg::CMD_WRITE, 63, 5, 1'b1);
        push_request(tlgs_pkg::CMD_WRITE, 0, 5, 1'b1);
        push_request(tlgs_pkg::CMD_WRITE, 1, 5, 1'b1);
        push_request(tlgs_pkg::CMD_STEP, 0, 0, 1'b0);
        push_request(tlgs_pkg::CMD_READ, 0, 4, 1'b0);
        push_request(tlgs_pkg::CMD_READ, 0, 6, 1'b0);
        push_request(tlgs_pkg::CMD_READ, 63, 5, 1'b0);
        push_request(tlgs_pkg::CMD_WRITE, 0, 5, 1'b0);
        fill_random(PHASE_ITEMS);
        wait_idle();

        for (int p = 0; p < PHASES; p++)
        begin
            apb_write(REG_WIDTH, phase_width[p]);
            apb_write(REG_HEIGHT, phase_height[p]);
            @(negedge clk);
            fill_random(PHASE_ITEMS);
            wait_idle();
        end

        repeat (100) @(negedge clk);
        if (fail_count == 0 && outcome_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
